// ===== sv/mkoc_pkg.sv =====
// Shared opcodes, command kinds and the queued command type for the keyword counter.
package mkoc_pkg;

   localparam logic [1:0] OP_KW_BYTE = 2'd0;
   localparam logic [1:0] OP_KW_LEN  = 2'd1;
   localparam logic [1:0] OP_TEXT    = 2'd2;
   localparam logic [1:0] OP_END     = 2'd3;

   localparam logic [2:0] KIND_NOP  = 3'd0;
   localparam logic [2:0] KIND_KWB  = 3'd1;
   localparam logic [2:0] KIND_LEN  = 3'd2;
   localparam logic [2:0] KIND_TEXT = 3'd3;
   localparam logic [2:0] KIND_STOP = 3'd4;
   localparam logic [2:0] KIND_END  = 3'd5;

   localparam int unsigned SCORE_W = 32;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] slot;
      logic [4:0] pos;
      logic [7:0] data;
      logic [6:0] len;
   } cmd_type;

endpackage

// ===== sv/multi_keyword_occurrence_counter_top.sv =====
// Top level of the multi-keyword occurrence counter.
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_stall | opcode, keyword_index, char_position,
//          |           |                      | byte_value, key_length
//  rsp     | out       | rsp_valid, rsp_stall | total_score, found
// One transaction per cycle while req_stall is low; a result passes through the queue,
// decode stage, match stage and output register after its end of text is accepted.
// Reset clears lengths, scan state, queue, rsp_valid; not keyword bytes or result data.
// The back end halts only while a result waits under rsp_stall and the next end of text
// reaches the output stage; req_stall rises when the queue is full.
module multi_keyword_occurrence_counter_top import mkoc_pkg::*; #(
   parameter int KEYWORDS = 8,
   parameter int MAXLEN   = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_opcode,
   input  logic [2:0]          req_keyword_index,
   input  logic [4:0]          req_char_position,
   input  logic [7:0]          req_byte_value,
   input  logic [5:0]          req_key_length,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SCORE_W-1:0]  rsp_total_score,
   output logic                rsp_found
);

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    q_full;
   logic    q_not_empty;
   logic    q_pop;

   assign req_stall = q_full;

   mkoc_front #(.KEYWORDS(KEYWORDS), .MAXLEN(MAXLEN)) u_front (
      .opcode        (req_opcode),
      .keyword_index (req_keyword_index),
      .char_position (req_char_position),
      .byte_value    (req_byte_value),
      .key_length    (req_key_length),
      .cmd           (front_cmd)
   );

   mkoc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !q_full),
      .push_cmd  (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (head_cmd)
   );

   mkoc_back #(.KEYWORDS(KEYWORDS), .MAXLEN(MAXLEN)) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (q_not_empty),
      .cmd             (head_cmd),
      .cmd_pop         (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_total_score (rsp_total_score),
      .rsp_found       (rsp_found)
   );

   a_found_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found == (rsp_total_score != '0)))
      else $error("found flag disagrees with score");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("outputs not idle after reset");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      (q_full && !q_pop) |=> q_full)
      else $error("queue lost an entry without a pop");

endmodule

// ===== sv/mkoc_front.sv =====
// Front end: decodes a request transaction into a classified command.
module mkoc_front import mkoc_pkg::*; #(
   parameter int KEYWORDS = 8,
   parameter int MAXLEN   = 32
) (
   input  logic [1:0] opcode,
   input  logic [2:0] keyword_index,
   input  logic [4:0] char_position,
   input  logic [7:0] byte_value,
   input  logic [5:0] key_length,
   output cmd_type    cmd
);

   logic slot_ok;
   logic pos_ok;

   assign slot_ok = 32'(keyword_index) < 32'(KEYWORDS);
   assign pos_ok  = 32'(char_position) < 32'(MAXLEN);

   always_comb begin
      cmd.slot = keyword_index;
      cmd.pos  = char_position;
      cmd.data = byte_value;
      if (32'(key_length) > 32'(MAXLEN)) begin
         cmd.len = 7'(MAXLEN);
      end else begin
         cmd.len = {1'b0, key_length};
      end
      unique case (opcode)
         OP_KW_BYTE: cmd.kind = (slot_ok && pos_ok) ? KIND_KWB : KIND_NOP;
         OP_KW_LEN:  cmd.kind = slot_ok ? KIND_LEN : KIND_NOP;
         OP_TEXT:    cmd.kind = (byte_value == 8'd0) ? KIND_STOP : KIND_TEXT;
         OP_END:     cmd.kind = KIND_END;
         default:    cmd.kind = KIND_NOP;
      endcase
   end

endmodule

// ===== sv/mkoc_queue.sv =====
// Two-entry command queue between front end and back end.
module mkoc_queue import mkoc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head
);

   cmd_type    mem [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign do_pop    = pop && not_empty;
   assign head      = mem[rd_ff];

   always_comb begin
      wr_in    = push ? ~wr_ff : wr_ff;
      rd_in    = do_pop ? ~rd_ff : rd_ff;
      count_in = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/mkoc_back.sv =====
// Back end: keyword store, text window, parallel match, score accumulate, result register.
module mkoc_back import mkoc_pkg::*; #(
   parameter int KEYWORDS = 8,
   parameter int MAXLEN   = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  cmd_type              cmd,
   output logic                 cmd_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [SCORE_W-1:0]   rsp_total_score,
   output logic                 rsp_found
);

   localparam int KIW = (KEYWORDS > 1) ? $clog2(KEYWORDS) : 1;
   localparam int PW  = $clog2(MAXLEN);
   localparam int LW  = $clog2(MAXLEN + 1);
   localparam int CW  = $clog2(KEYWORDS + 1);

   logic [7:0]          kw_ff   [KEYWORDS][MAXLEN];
   logic [LW-1:0]       len_ff  [KEYWORDS];
   logic [7:0]          win_ff  [MAXLEN];
   logic [LW-1:0]       fill_ff, fill_in;
   logic                stop_ff, stop_in;
   logic                p1_text_ff, p1_text_in;
   logic                p1_end_ff, p1_end_in;
   logic                p2_text_ff;
   logic                p2_end_ff;
   logic [KEYWORDS-1:0] hit_ff, hit_in;
   logic [SCORE_W-1:0]  score_ff, score_in;
   logic                out_valid_ff, out_valid_in;
   logic [SCORE_W-1:0]  out_score_ff;
   logic                out_found_ff;
   logic                advance;
   logic                take;
   logic [KIW-1:0]      sidx;
   logic [PW-1:0]       pidx;
   logic [CW-1:0]       hit_cnt;
   logic [SCORE_W:0]    sum;

   assign advance = !(p2_end_ff && out_valid_ff && rsp_stall);
   assign cmd_pop = advance;
   assign take    = advance && cmd_valid;
   assign sidx    = KIW'(cmd.slot);
   assign pidx    = PW'(cmd.pos);

   assign rsp_valid       = out_valid_ff;
   assign rsp_total_score = out_score_ff;
   assign rsp_found       = out_found_ff;

   always_comb begin
      fill_in    = fill_ff;
      stop_in    = stop_ff;
      p1_text_in = 1'b0;
      p1_end_in  = 1'b0;
      if (take) begin
         case (cmd.kind)
            KIND_TEXT: begin
               if (!stop_ff) begin
                  p1_text_in = 1'b1;
                  if (fill_ff != LW'(MAXLEN)) begin
                     fill_in = fill_ff + 1'b1;
                  end
               end
            end
            KIND_STOP: stop_in = 1'b1;
            KIND_END: begin
               p1_end_in = 1'b1;
               fill_in   = '0;
               stop_in   = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [LW-1:0] d;
      logic          all_eq;
      for (int k = 0; k < KEYWORDS; k++) begin
         all_eq = 1'b1;
         for (int p = 0; p < MAXLEN; p++) begin
            d = len_ff[k] - LW'(p) - 1'b1;
            if (LW'(p) < len_ff[k] && kw_ff[k][p] != win_ff[d[PW-1:0]]) begin
               all_eq = 1'b0;
            end
         end
         hit_in[k] = p1_text_ff && (len_ff[k] != '0) && (len_ff[k] <= fill_ff) && all_eq;
      end
   end

   always_comb begin
      hit_cnt = '0;
      for (int k = 0; k < KEYWORDS; k++) begin
         hit_cnt = hit_cnt + CW'(hit_ff[k]);
      end
      sum          = {1'b0, score_ff} + (SCORE_W + 1)'(hit_cnt);
      score_in     = score_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (advance && p2_text_ff) begin
         score_in = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
      end
      if (advance && p2_end_ff) begin
         score_in     = '0;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take && cmd.kind == KIND_KWB) begin
         kw_ff[sidx][pidx] <= cmd.data;
      end
      if (take && cmd.kind == KIND_TEXT && !stop_ff) begin
         win_ff[0] <= cmd.data;
         for (int i = 1; i < MAXLEN; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
      if (advance) begin
         hit_ff <= hit_in;
      end
      if (advance && p2_end_ff) begin
         out_score_ff <= score_ff;
         out_found_ff <= score_ff != '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEYWORDS; k++) begin
            len_ff[k] <= '0;
         end
         fill_ff      <= '0;
         stop_ff      <= 1'b0;
         p1_text_ff   <= 1'b0;
         p1_end_ff    <= 1'b0;
         p2_text_ff   <= 1'b0;
         p2_end_ff    <= 1'b0;
         score_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take && cmd.kind == KIND_LEN) begin
            len_ff[sidx] <= LW'(cmd.len);
         end
         fill_ff      <= fill_in;
         stop_ff      <= stop_in;
         if (advance) begin
            p1_text_ff <= p1_text_in;
            p1_end_ff  <= p1_end_in;
            p2_text_ff <= p1_text_ff;
            p2_end_ff  <= p1_end_ff;
         end
         score_ff     <= score_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
